@@ rtl/dtr_pkg.sv @@
// shared types, constants and letter tables for the roman numeral converter
`default_nettype none
package dtr_pkg;

    localparam int VALUE_W     = 12;
    localparam int CHAR_W      = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam int RADIX = 10;

    // floor(v / 10^n) = (v * recip) >> shift, exact for every 12-bit v
    localparam int RECIP10    = 3277;
    localparam int RECIP100   = 5243;
    localparam int RECIP1000  = 8389;

    localparam logic [CHAR_W-1:0] CH_M  = 7'd77;
    localparam logic [CHAR_W-1:0] CH_D  = 7'd68;
    localparam logic [CHAR_W-1:0] CH_C  = 7'd67;
    localparam logic [CHAR_W-1:0] CH_L  = 7'd76;
    localparam logic [CHAR_W-1:0] CH_X  = 7'd88;
    localparam logic [CHAR_W-1:0] CH_V  = 7'd86;
    localparam logic [CHAR_W-1:0] CH_I  = 7'd73;
    localparam logic [CHAR_W-1:0] CH_NL = 7'd10;

    // decimal places, most significant first; PL_END marks the newline
    typedef enum logic [2:0] {
        PL_THOU  = 3'd0,
        PL_HUND  = 3'd1,
        PL_TENS  = 3'd2,
        PL_UNITS = 3'd3,
        PL_END   = 3'd4
    } t_place;

    // which of a place's three letters a pattern position uses
    typedef enum logic [1:0] {
        SYM_ONE  = 2'd0,
        SYM_FIVE = 2'd1,
        SYM_TEN  = 2'd2
    } t_sym;

    typedef struct packed {
        logic [2:0] thou;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] units;
    } t_digits;

    // number of letters a digit spells in a given place
    function automatic logic [2:0] f_len(input t_place place, input logic [3:0] digit);
        logic [2:0] len;
        len = 3'd0;
        if (place == PL_THOU) begin
            len = digit[2:0];
        end else begin
            case (digit)
                4'd1, 4'd5:       len = 3'd1;
                4'd2, 4'd4, 4'd6,
                4'd9:             len = 3'd2;
                4'd3, 4'd7:       len = 3'd3;
                4'd8:             len = 3'd4;
                default:          len = 3'd0;
            endcase
        end
        return len;
    endfunction

    function automatic t_sym f_sym(input logic [3:0] digit, input logic [1:0] pos);
        t_sym s;
        s = SYM_ONE;
        case (digit)
            4'd4: s = (pos == 2'd1) ? SYM_FIVE : SYM_ONE;
            4'd5, 4'd6, 4'd7,
            4'd8: s = (pos == 2'd0) ? SYM_FIVE : SYM_ONE;
            4'd9: s = (pos == 2'd1) ? SYM_TEN : SYM_ONE;
            default: s = SYM_ONE;
        endcase
        return s;
    endfunction

    function automatic logic [CHAR_W-1:0] f_letter(input t_place place,
                                                   input logic [3:0] digit,
                                                   input logic [1:0] pos);
        logic [CHAR_W-1:0] ch;
        t_sym              s;
        s  = f_sym(digit, pos);
        ch = CH_M;
        case (place)
            PL_THOU:  ch = CH_M;
            PL_HUND:  ch = (s == SYM_ONE) ? CH_C : (s == SYM_FIVE) ? CH_D : CH_M;
            PL_TENS:  ch = (s == SYM_ONE) ? CH_X : (s == SYM_FIVE) ? CH_L : CH_C;
            PL_UNITS: ch = (s == SYM_ONE) ? CH_I : (s == SYM_FIVE) ? CH_V : CH_X;
            default:  ch = CH_NL;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

@@ rtl/dtr_if.sv @@
// valid/ready channel interfaces for numbers in and characters out
`default_nettype none
interface dtr_in_if;
    logic                          valid;
    logic                          ready;
    logic [dtr_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface dtr_out_if;
    logic                          valid;
    logic                          ready;
    logic [dtr_pkg::CHAR_W-1:0]    char_code;
    logic                          last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/dtr_front.sv @@
// front end: accepts a number and splits it into decimal digits
`default_nettype none
module dtr_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    dtr_in_if.sink           i_in,
    output logic             o_valid,
    input  wire              i_ready,
    output dtr_pkg::t_digits o_digits
);

    logic                    r_valid;
    logic                    n_valid;
    dtr_pkg::t_digits        r_digits;
    dtr_pkg::t_digits        n_digits;
    logic                    w_take;

    logic [23:0] w_p10;
    logic [24:0] w_p100;
    logic [25:0] w_p1000;
    logic [8:0]  w_q10;
    logic [5:0]  w_q100;
    logic [2:0]  w_q1000;
    logic [11:0] w_units;
    logic [8:0]  w_tens;
    logic [5:0]  w_hund;

    assign i_in.ready = !r_valid || i_ready;
    assign w_take     = i_in.valid && i_in.ready;

    always_comb begin
        w_p10   = 24'(i_in.value) * 24'(dtr_pkg::RECIP10);
        w_p100  = 25'(i_in.value) * 25'(dtr_pkg::RECIP100);
        w_p1000 = 26'(i_in.value) * 26'(dtr_pkg::RECIP1000);
        w_q10   = w_p10[23:15];
        w_q100  = w_p100[24:19];
        w_q1000 = w_p1000[25:23];
        // remainders by subtracting the scaled next quotient
        w_units = i_in.value - 12'(w_q10) * 12'(dtr_pkg::RADIX);
        w_tens  = w_q10 - 9'(w_q100) * 9'(dtr_pkg::RADIX);
        w_hund  = w_q100 - 6'(w_q1000) * 6'(dtr_pkg::RADIX);
        n_digits.thou  = w_q1000;
        n_digits.hund  = w_hund[3:0];
        n_digits.tens  = w_tens[3:0];
        n_digits.units = w_units[3:0];
        n_valid = w_take ? 1'b1 : (i_ready ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_digits <= n_digits;
        end
    end

    assign o_valid  = r_valid;
    assign o_digits = r_digits;

endmodule
`default_nettype wire

@@ rtl/dtr_queue.sv @@
// short fifo of digit sets between front and back
`default_nettype none
module dtr_queue #(
    parameter int DEPTH = dtr_pkg::QUEUE_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  dtr_pkg::t_digits i_data,
    output logic             o_valid,
    input  wire              i_ready,
    output dtr_pkg::t_digits o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    dtr_pkg::t_digits r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    n_wr;
    logic [AW-1:0]    r_rd;
    logic [AW-1:0]    n_rd;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

@@ rtl/dtr_back.sv @@
// back end: walks the digit patterns and sends one character per beat
`default_nettype none
module dtr_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  dtr_pkg::t_digits i_digits,
    dtr_out_if.source        o_out
);

    dtr_pkg::t_place              r_place;
    dtr_pkg::t_place              n_place;
    logic [1:0]                   r_pos;
    logic [1:0]                   n_pos;
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic [dtr_pkg::CHAR_W-1:0]   r_char;
    logic [dtr_pkg::CHAR_W-1:0]   n_char;
    logic                         r_last;
    logic                         n_last;

    logic [3:0]                   w_dig [4];
    logic [2:0]                   w_len [4];
    dtr_pkg::t_place              w_cur;
    logic                         w_found;
    logic                         w_emit;
    logic [2:0]                   w_pos_inc;

    assign w_emit    = i_valid && (!r_out_valid || o_out.ready);
    assign w_pos_inc = {1'b0, r_pos} + 3'd1;

    always_comb begin
        w_dig[0] = {1'b0, i_digits.thou};
        w_dig[1] = i_digits.hund;
        w_dig[2] = i_digits.tens;
        w_dig[3] = i_digits.units;
        for (int p = 0; p < 4; p++) begin
            w_len[p] = dtr_pkg::f_len(dtr_pkg::t_place'(3'(p)), w_dig[p]);
        end

        // first place from here on that spells any letter
        w_cur   = dtr_pkg::PL_END;
        w_found = 1'b0;
        for (int p = 0; p < 4; p++) begin
            if (!w_found && (3'(p) >= r_place) && (w_len[p] != 3'd0)) begin
                w_cur   = dtr_pkg::t_place'(3'(p));
                w_found = 1'b1;
            end
        end
    end

    always_comb begin
        n_place     = r_place;
        n_pos       = r_pos;
        n_char      = r_char;
        n_last      = r_last;
        n_out_valid = r_out_valid && !o_out.ready;
        o_ready     = 1'b0;
        if (w_emit) begin
            n_out_valid = 1'b1;
            if (w_cur == dtr_pkg::PL_END) begin
                n_char  = dtr_pkg::CH_NL;
                n_last  = 1'b1;
                n_place = dtr_pkg::PL_THOU;
                n_pos   = 2'd0;
                o_ready = 1'b1;
            end else begin
                n_char = dtr_pkg::f_letter(w_cur, w_dig[w_cur[1:0]], r_pos);
                n_last = 1'b0;
                if (w_pos_inc < w_len[w_cur[1:0]]) begin
                    n_place = w_cur;
                    n_pos   = w_pos_inc[1:0];
                end else begin
                    n_place = dtr_pkg::t_place'(w_cur + 3'd1);
                    n_pos   = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_place     <= dtr_pkg::PL_THOU;
            r_pos       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_place     <= n_place;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_char <= n_char;
            r_last <= n_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_char;
    assign o_out.last      = r_last;

endmodule
`default_nettype wire

@@ rtl/decimal_to_roman_numeral_core.sv @@
// top level of the decimal to roman numeral converter
//
// channel  dir  payload                         beat
// i_in     in   value[11:0]                     one number
// o_out    out  char_code[6:0], last            one character, last on newline
//
// a number gives its letters then a newline, one character per cycle while
// o_out is ready, held in the back end's single output register.
// the front splits the digits into a register; a short fifo lets it take new
// numbers while the back end is still spelling an earlier one.
// reset is synchronous and clears only control state; either side may stall.
`default_nettype none
module decimal_to_roman_numeral_core #(
    parameter int QUEUE_DEPTH = dtr_pkg::QUEUE_DEPTH
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    dtr_in_if.sink    i_in,
    dtr_out_if.source o_out
);

    logic             w_f_valid;
    logic             w_f_ready;
    dtr_pkg::t_digits w_f_digits;
    logic             w_q_valid;
    logic             w_q_ready;
    dtr_pkg::t_digits w_q_digits;

    dtr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_valid  (w_f_valid),
        .i_ready  (w_f_ready),
        .o_digits (w_f_digits)
    );

    dtr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_digits),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_digits)
    );

    dtr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .o_ready  (w_q_ready),
        .i_digits (w_q_digits),
        .o_out    (o_out)
    );

endmodule
`default_nettype wire
